>>> hw/rtl/sn64_pkg.sv
// ----------------------------------------------------------------------------
// sn64_pkg
// Shared types and constants for the stateless NAT64 header translator.
// ----------------------------------------------------------------------------
package sn64_pkg;

    localparam logic [31:0] ROUTER_RESET  = 32'h0a00_0001;
    localparam logic [31:0] PREFIX_RESET  = 32'h2001_0db8;

    localparam logic [15:0] HDR_BYTES     = 16'd20;
    localparam logic [15:0] MAX_PLEN      = 16'hffff - HDR_BYTES;
    localparam logic [15:0] VER_IHL_TOS   = 16'h4500;
    localparam logic [15:0] DF_FLAG       = 16'h4000;
    localparam logic [7:0]  PROTO_ICMPV6  = 8'd58;
    localparam logic [7:0]  PROTO_ICMP    = 8'd1;
    localparam logic [31:0] PTR_LAST      = 32'd39;

    // icmpv6 types
    localparam logic [7:0] ICMP6_DST_UNREACH  = 8'd1;
    localparam logic [7:0] ICMP6_PKT_TOO_BIG  = 8'd2;
    localparam logic [7:0] ICMP6_TIME_EXCEED  = 8'd3;
    localparam logic [7:0] ICMP6_PARAM_PROB   = 8'd4;
    localparam logic [7:0] ICMP6_ECHO_REQ     = 8'd128;
    localparam logic [7:0] ICMP6_ECHO_REP     = 8'd129;

    // icmpv4 types
    localparam logic [7:0] ICMP4_ECHO_REP     = 8'd0;
    localparam logic [7:0] ICMP4_DST_UNREACH  = 8'd3;
    localparam logic [7:0] ICMP4_ECHO_REQ     = 8'd8;
    localparam logic [7:0] ICMP4_TIME_EXCEED  = 8'd11;
    localparam logic [7:0] ICMP4_PARAM_PROB   = 8'd12;

    typedef enum logic [1:0] {
        VERDICT_OK       = 2'd0,
        VERDICT_MISMATCH = 2'd1,
        VERDICT_ICMP_BAD = 2'd2,
        VERDICT_LEN_OVF  = 2'd3
    } verdict_t;

    typedef enum logic [0:0] {
        REG_ROUTER_IPV4 = 1'b0,
        REG_NAT_PREFIX  = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [31:0] dst_prefix_word;
        logic [31:0] dst_ipv4;
        logic [7:0]  next_header;
        logic [7:0]  hlim;
        logic [15:0] payload_length;
        logic [7:0]  icmpv6_type;
        logic [7:0]  icmpv6_code;
        logic [31:0] icmp6_rest;
    } hdr_t;

    typedef struct packed {
        verdict_t    verdict;
        logic        icmp;
        logic [15:0] total_length;
        logic [7:0]  protocol;
        logic [7:0]  ttl;
        logic [31:0] destination;
        logic [7:0]  icmp_type;
        logic [7:0]  icmp_code;
        logic [31:0] icmp_rest;
    } hdr_dec_t;

    typedef struct packed {
        hdr_dec_t    dec;
        logic [18:0] ip_acc;
        logic [17:0] icmp_acc;
    } hdr_sum_t;

    typedef struct packed {
        verdict_t    verdict;
        logic [15:0] ipv4_total_length;
        logic [7:0]  ipv4_protocol;
        logic [7:0]  ipv4_ttl;
        logic [31:0] ipv4_destination;
        logic [15:0] ipv4_header_checksum;
        logic [7:0]  icmp_type;
        logic [7:0]  icmp_code;
        logic [31:0] icmp_rest;
        logic [15:0] icmp_checksum;
    } res_t;

endpackage

>>> hw/rtl/sn64_if.sv
// ----------------------------------------------------------------------------
// sn64 channel interfaces
// Valid/ready channels for header requests and translation results.
// ----------------------------------------------------------------------------
interface sn64_hdr_if;
    logic        valid;
    logic        ready;
    logic [31:0] dst_prefix_word;
    logic [31:0] dst_ipv4;
    logic [7:0]  next_header;
    logic [7:0]  hlim;
    logic [15:0] payload_length;
    logic [7:0]  icmpv6_type;
    logic [7:0]  icmpv6_code;
    logic [31:0] icmp6_rest;

    modport source (
        output valid, dst_prefix_word, dst_ipv4, next_header, hlim,
               payload_length, icmpv6_type, icmpv6_code, icmp6_rest,
        input  ready
    );
    modport sink (
        input  valid, dst_prefix_word, dst_ipv4, next_header, hlim,
               payload_length, icmpv6_type, icmpv6_code, icmp6_rest,
        output ready
    );
endinterface

interface sn64_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  verdict;
    logic [15:0] ipv4_total_length;
    logic [7:0]  ipv4_protocol;
    logic [7:0]  ipv4_ttl;
    logic [31:0] ipv4_destination;
    logic [15:0] ipv4_header_checksum;
    logic [7:0]  icmp_type;
    logic [7:0]  icmp_code;
    logic [31:0] icmp_rest;
    logic [15:0] icmp_checksum;

    modport source (
        output valid, verdict, ipv4_total_length, ipv4_protocol, ipv4_ttl,
               ipv4_destination, ipv4_header_checksum, icmp_type, icmp_code,
               icmp_rest, icmp_checksum,
        input  ready
    );
    modport sink (
        input  valid, verdict, ipv4_total_length, ipv4_protocol, ipv4_ttl,
               ipv4_destination, ipv4_header_checksum, icmp_type, icmp_code,
               icmp_rest, icmp_checksum,
        output ready
    );
endinterface

>>> hw/rtl/sn64_cfg.sv
// ----------------------------------------------------------------------------
// sn64_cfg
// APB register file holding the router address and the NAT64 prefix word.
// ----------------------------------------------------------------------------
module sn64_cfg (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [31:0] router_ipv4,
    output logic [31:0] nat_prefix
);
    import sn64_pkg::*;

    logic [31:0] router_ipv4_reg;
    logic [31:0] nat_prefix_reg;
    logic        wr_en;
    cfg_reg_t    sel;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign sel    = cfg_reg_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            router_ipv4_reg <= ROUTER_RESET;
            nat_prefix_reg  <= PREFIX_RESET;
        end
        else if (wr_en)
        begin
            unique case (sel)
                REG_ROUTER_IPV4: router_ipv4_reg <= pwdata;
                REG_NAT_PREFIX:  nat_prefix_reg  <= pwdata;
                default:         router_ipv4_reg <= router_ipv4_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            REG_ROUTER_IPV4: prdata = router_ipv4_reg;
            REG_NAT_PREFIX:  prdata = nat_prefix_reg;
            default:         prdata = '0;
        endcase
    end

    assign router_ipv4 = router_ipv4_reg;
    assign nat_prefix  = nat_prefix_reg;

endmodule

>>> hw/rtl/sn64_decode.sv
// ----------------------------------------------------------------------------
// sn64_decode
// Stage 1: prefix match, length check and ICMPv6 to ICMPv4 mapping.
// ----------------------------------------------------------------------------
module sn64_decode (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [31:0]         nat_prefix,
    input  logic                in_valid,
    output logic                in_ready,
    input  sn64_pkg::hdr_t      in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output sn64_pkg::hdr_dec_t  out_data
);
    import sn64_pkg::*;

    logic        valid_reg;
    hdr_dec_t    data_reg;
    hdr_dec_t    data_next;
    logic [7:0]  t4;
    logic [7:0]  c4;
    logic [31:0] r4;
    logic        map_ok;
    logic [7:0]  ptr;
    logic [31:0] mtu;
    logic        is_icmp;
    logic        mismatch;
    logic        len_ovf;

    assign in_ready = !valid_reg || out_ready;

    // icmp type/code/rest mapping
    always_comb
    begin
        t4     = '0;
        c4     = '0;
        r4     = '0;
        map_ok = 1'b1;
        ptr    = '0;
        mtu    = in_data.icmp6_rest - 32'(HDR_BYTES);
        unique case (in_data.icmpv6_type)
            ICMP6_ECHO_REQ:
            begin
                t4 = ICMP4_ECHO_REQ;
                r4 = in_data.icmp6_rest;
            end
            ICMP6_ECHO_REP:
            begin
                t4 = ICMP4_ECHO_REP;
                r4 = in_data.icmp6_rest;
            end
            ICMP6_DST_UNREACH:
            begin
                t4 = ICMP4_DST_UNREACH;
                unique case (in_data.icmpv6_code)
                    8'd0, 8'd2, 8'd3: c4 = 8'd1;
                    8'd1:             c4 = 8'd10;
                    8'd4:             c4 = 8'd3;
                    default:          map_ok = 1'b0;
                endcase
            end
            ICMP6_PKT_TOO_BIG:
            begin
                t4     = ICMP4_DST_UNREACH;
                c4     = 8'd4;
                map_ok = (in_data.icmp6_rest >= 32'(HDR_BYTES))
                      && (in_data.icmp6_rest <= 32'hffff + 32'(HDR_BYTES));
                r4     = {16'd0, mtu[15:0]};
            end
            ICMP6_TIME_EXCEED:
            begin
                t4 = ICMP4_TIME_EXCEED;
                c4 = in_data.icmpv6_code;
            end
            ICMP6_PARAM_PROB:
            begin
                if (in_data.icmpv6_code == 8'd0)
                begin
                    t4 = ICMP4_PARAM_PROB;
                    // ipv6 header offset to ipv4 header offset
                    priority if (in_data.icmp6_rest <= 32'd1)
                        ptr = in_data.icmp6_rest[7:0];
                    else if (in_data.icmp6_rest == 32'd4 || in_data.icmp6_rest == 32'd5)
                        ptr = 8'd2;
                    else if (in_data.icmp6_rest == 32'd6)
                        ptr = 8'd9;
                    else if (in_data.icmp6_rest == 32'd7)
                        ptr = 8'd8;
                    else if (in_data.icmp6_rest >= 32'd8 && in_data.icmp6_rest <= 32'd23)
                        ptr = 8'd12;
                    else if (in_data.icmp6_rest >= 32'd24 && in_data.icmp6_rest <= PTR_LAST)
                        ptr = 8'd16;
                    else
                        map_ok = 1'b0;
                    r4 = {ptr, 24'd0};
                end
                else if (in_data.icmpv6_code == 8'd1)
                begin
                    t4 = ICMP4_DST_UNREACH;
                    c4 = 8'd2;
                end
                else
                begin
                    map_ok = 1'b0;
                end
            end
            default: map_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        is_icmp  = (in_data.next_header == PROTO_ICMPV6);
        mismatch = (in_data.dst_prefix_word != nat_prefix);
        len_ovf  = (in_data.payload_length > MAX_PLEN);
        data_next = '0;
        priority if (mismatch)
            data_next.verdict = VERDICT_MISMATCH;
        else if (len_ovf)
            data_next.verdict = VERDICT_LEN_OVF;
        else if (is_icmp && !map_ok)
            data_next.verdict = VERDICT_ICMP_BAD;
        else
        begin
            data_next.verdict      = VERDICT_OK;
            data_next.icmp         = is_icmp;
            data_next.total_length = in_data.payload_length + HDR_BYTES;
            data_next.protocol     = is_icmp ? PROTO_ICMP : in_data.next_header;
            data_next.ttl          = in_data.hlim;
            data_next.destination  = in_data.dst_ipv4;
            if (is_icmp)
            begin
                data_next.icmp_type = t4;
                data_next.icmp_code = c4;
                data_next.icmp_rest = r4;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> hw/rtl/sn64_sum.sv
// ----------------------------------------------------------------------------
// sn64_sum
// Stage 2: unfolded 16-bit word sums for the IPv4 and ICMPv4 checksums.
// ----------------------------------------------------------------------------
module sn64_sum (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [31:0]         router_ipv4,
    input  logic                in_valid,
    output logic                in_ready,
    input  sn64_pkg::hdr_dec_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output sn64_pkg::hdr_sum_t  out_data
);
    import sn64_pkg::*;

    logic     valid_reg;
    hdr_sum_t data_reg;
    hdr_sum_t data_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        data_next.dec    = in_data;
        data_next.ip_acc = 19'(VER_IHL_TOS) + 19'(in_data.total_length) + 19'(DF_FLAG)
                         + 19'({in_data.ttl, in_data.protocol})
                         + 19'(router_ipv4[31:16]) + 19'(router_ipv4[15:0])
                         + 19'(in_data.destination[31:16])
                         + 19'(in_data.destination[15:0]);
        data_next.icmp_acc = 18'({in_data.icmp_type, in_data.icmp_code})
                           + 18'(in_data.icmp_rest[31:16])
                           + 18'(in_data.icmp_rest[15:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> hw/rtl/sn64_fold.sv
// ----------------------------------------------------------------------------
// sn64_fold
// Stage 3: end-around carry fold, complement and result register.
// ----------------------------------------------------------------------------
module sn64_fold (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sn64_pkg::hdr_sum_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output sn64_pkg::res_t      out_data
);
    import sn64_pkg::*;

    logic        valid_reg;
    res_t        data_reg;
    res_t        data_next;
    logic [16:0] ip_s1;
    logic [16:0] ip_s2;
    logic [16:0] ic_s1;
    logic [16:0] ic_s2;
    logic        ok;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        ip_s1 = 17'(in_data.ip_acc[18:16]) + 17'(in_data.ip_acc[15:0]);
        ip_s2 = ip_s1 + 17'(ip_s1[16]);
        ic_s1 = 17'(in_data.icmp_acc[17:16]) + 17'(in_data.icmp_acc[15:0]);
        ic_s2 = ic_s1 + 17'(ic_s1[16]);
        ok    = (in_data.dec.verdict == VERDICT_OK);

        data_next.verdict              = in_data.dec.verdict;
        data_next.ipv4_total_length    = in_data.dec.total_length;
        data_next.ipv4_protocol        = in_data.dec.protocol;
        data_next.ipv4_ttl             = in_data.dec.ttl;
        data_next.ipv4_destination     = in_data.dec.destination;
        data_next.ipv4_header_checksum = ok ? ~ip_s2[15:0] : 16'd0;
        data_next.icmp_type            = in_data.dec.icmp_type;
        data_next.icmp_code            = in_data.dec.icmp_code;
        data_next.icmp_rest            = in_data.dec.icmp_rest;
        data_next.icmp_checksum        = (ok && in_data.dec.icmp) ? ~ic_s2[15:0] : 16'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> hw/rtl/stateless_nat64_header_translate.sv
// ----------------------------------------------------------------------------
// stateless_nat64_header_translate
// IPv6 to IPv4 stateless header translation with ICMP mapping and checksums.
// ----------------------------------------------------------------------------
// One header request is taken every clock cycle while hdr.ready is high, and
// each produces exactly one result. There are three register stages: decode
// (prefix match, length check, ICMP mapping), sum (checksum word sums) and
// fold (carry fold and complement, which also is the output register).
// Every stage has its own valid bit and takes a new request whenever it is
// empty or its result moves on, so a stall at the result side only fills the
// pipeline. The router address and prefix registers are written over APB at
// byte addresses 0 and 4 and must only be changed while the pipeline is empty.
module stateless_nat64_header_translate (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    sn64_hdr_if.sink    hdr,
    sn64_res_if.source  res
);
    import sn64_pkg::*;

    logic [31:0] router_ipv4;
    logic [31:0] nat_prefix;
    hdr_t        hdr_data;
    logic        dec_valid;
    logic        dec_ready;
    hdr_dec_t    dec_data;
    logic        sum_valid;
    logic        sum_ready;
    hdr_sum_t    sum_data;
    res_t        res_data;

    sn64_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .router_ipv4 (router_ipv4),
        .nat_prefix  (nat_prefix)
    );

    always_comb
    begin
        hdr_data.dst_prefix_word = hdr.dst_prefix_word;
        hdr_data.dst_ipv4        = hdr.dst_ipv4;
        hdr_data.next_header     = hdr.next_header;
        hdr_data.hlim            = hdr.hlim;
        hdr_data.payload_length  = hdr.payload_length;
        hdr_data.icmpv6_type     = hdr.icmpv6_type;
        hdr_data.icmpv6_code     = hdr.icmpv6_code;
        hdr_data.icmp6_rest      = hdr.icmp6_rest;
    end

    sn64_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .nat_prefix (nat_prefix),
        .in_valid   (hdr.valid),
        .in_ready   (hdr.ready),
        .in_data    (hdr_data),
        .out_valid  (dec_valid),
        .out_ready  (dec_ready),
        .out_data   (dec_data)
    );

    sn64_sum u_sum (
        .clk         (clk),
        .rst_n       (rst_n),
        .router_ipv4 (router_ipv4),
        .in_valid    (dec_valid),
        .in_ready    (dec_ready),
        .in_data     (dec_data),
        .out_valid   (sum_valid),
        .out_ready   (sum_ready),
        .out_data    (sum_data)
    );

    sn64_fold u_fold (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sum_valid),
        .in_ready  (sum_ready),
        .in_data   (sum_data),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .out_data  (res_data)
    );

    always_comb
    begin
        res.verdict              = res_data.verdict;
        res.ipv4_total_length    = res_data.ipv4_total_length;
        res.ipv4_protocol        = res_data.ipv4_protocol;
        res.ipv4_ttl             = res_data.ipv4_ttl;
        res.ipv4_destination     = res_data.ipv4_destination;
        res.ipv4_header_checksum = res_data.ipv4_header_checksum;
        res.icmp_type            = res_data.icmp_type;
        res.icmp_code            = res_data.icmp_code;
        res.icmp_rest            = res_data.icmp_rest;
        res.icmp_checksum        = res_data.icmp_checksum;
    end

endmodule
